/* design/hci_pkg.sv */
// Shared constants, types and helper functions for the HSL colour interpolator.
// No dependencies; every other design file refers to this package by scoped name.
package hci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;            // fraction bits plus the ONE bit
    localparam logic [FW-1:0] ONE_FX        = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] THIRD_FX      = FW'((64'd1 << FRAC_BITS) / 3);
    localparam logic [FW-1:0] TWO_THIRDS_FX = FW'((64'd2 << FRAC_BITS) / 3);
    localparam int QDEPTH    = 2;

    // Divider shape shared by every divider instance
    localparam int DIV_DW    = 11;
    localparam int DIV_NW    = DIV_DW + FRAC_BITS;
    localparam int DIV_QW    = FW;

    // Lightness sum*ONE/510 as (sum * LR_RECIP) >> LR_SHIFT, exact for sums up to 510
    localparam int LR_W      = FRAC_BITS + 9;
    localparam int LR_SHIFT  = 17;
    localparam logic [LR_W-1:0] LR_RECIP =
        LR_W'(((64'd1 << (FRAC_BITS + 16)) + 64'd254) / 64'd255);

    typedef struct packed {
        logic [FW-1:0] h;
        logic [FW-1:0] s;
        logic [FW-1:0] l;
    } hsl_t;

    // Queued beat handed from the front part to the back part
    typedef struct packed {
        logic [23:0] color_a;
        logic [23:0] color_b;
        logic [8:0]  t;
    } item_t;

endpackage

/* design/hci_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on hci_pkg.
module hci_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [hci_pkg::DIV_NW-1:0]     num,
    input  logic [hci_pkg::DIV_DW-1:0]     den,
    output logic [hci_pkg::DIV_QW-1:0]     quo
);
    localparam int NW = hci_pkg::DIV_NW;
    localparam int DW = hci_pkg::DIV_DW;
    localparam int QW = hci_pkg::DIV_QW;
    localparam int RW = DW + 1;

    logic [RW-1:0] rem_reg [QW+1];
    logic [NW-1:0] num_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];

    // Load the first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num >> QW);
            num_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [RW:0] trial;
        assign trial = {rem_reg[i], num_reg[i][QW-1-i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i+1] <= num_reg[i];
                den_reg[i+1] <= den_reg[i];
                if (trial >= {1'b0, 1'b0, den_reg[i]})
                begin
                    rem_reg[i+1] <= RW'(trial - {2'b00, den_reg[i]});
                    q_reg[i+1]   <= q_reg[i] | (QW'(1) << (QW-1-i));
                end
                else
                begin
                    rem_reg[i+1] <= RW'(trial);
                    q_reg[i+1]   <= q_reg[i];
                end
            end
        end
    end

    assign quo = q_reg[QW];
endmodule

/* design/hci_front.sv */
// Front part: accept beats, saturate the fraction, push into a short queue.
// Depends on hci_pkg.
module hci_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic [23:0]         color_a,
    input  logic [23:0]         color_b,
    input  logic [8:0]          mix_fraction,
    output logic                q_valid,
    input  logic                q_pop,
    output hci_pkg::item_t      q_item
);
    hci_pkg::item_t mem_reg [hci_pkg::QDEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    hci_pkg::item_t in_item;

    assign ready = (cnt_reg != 2'(hci_pkg::QDEPTH));
    assign push  = valid && ready;

    // Saturate the fraction at 256
    always_comb
    begin
        in_item.color_a = color_a;
        in_item.color_b = color_b;
        in_item.t       = mix_fraction[8] ? 9'd256 : mix_fraction;
    end

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rp_reg];
endmodule

/* design/hci_back.sv */
// Back part: RGB to HSL, blend, HSL to RGB, as a stall-together pipeline with skid output.
// Depends on hci_pkg and hci_div.
module hci_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_pop,
    input  hci_pkg::item_t q_item,
    output logic           valid,
    input  logic           ready,
    output logic [23:0]    color_out
);
    localparam int FB = hci_pkg::FRAC_BITS;
    localparam int FW = hci_pkg::FW;
    localparam int NS = FW + 1 + 1 + 1 + 3; // div latency + front stage + blend + rgb stages
    localparam int DL = FW + 1;             // divider latency
    localparam int NW = hci_pkg::DIV_NW;
    localparam int DW = hci_pkg::DIV_DW;
    localparam int LR_W = hci_pkg::LR_W;

    logic en;
    logic [NS-1:0] v_reg;
    logic          out_valid_reg;
    logic [23:0]   out_reg;

    // Stall everything together; stage bubbles carry v=0
    assign en    = !out_valid_reg || ready || !v_reg[NS-1];
    assign q_pop = q_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], q_pop};
    end

    // Stage 0: per-colour classification
    typedef struct packed {
        logic [8:0]  sum;
        logic        grey;
        logic [7:0]  diff;
        logic [10:0] hnum;
    } cls_t;

    function automatic cls_t classify(input logic [23:0] c);
        logic [7:0] r, g, b, mx, mn;
        logic signed [11:0] num;
        cls_t o;
        r = c[23:16]; g = c[15:8]; b = c[7:0];
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        o.diff = mx - mn;
        o.sum  = {1'b0, mx} + {1'b0, mn};
        o.grey = (o.diff == 8'd0);
        if (mx == b)
            num = 12'sd4 * $signed({4'd0, o.diff}) + $signed({4'd0, r}) - $signed({4'd0, g});
        else if (mx == g)
            num = 12'sd2 * $signed({4'd0, o.diff}) + $signed({4'd0, b}) - $signed({4'd0, r});
        else
            num = $signed({4'd0, g}) - $signed({4'd0, b});
        if (num < 0)
            num = num + 12'sd6 * $signed({4'd0, o.diff});
        o.hnum = 11'(num);
        return o;
    endfunction

    // Lightness by reciprocal multiplication
    function automatic logic [FW-1:0] lightness(input logic [8:0] sum);
        logic [LR_W+8:0] p;
        p = (LR_W+9)'(sum) * (LR_W+9)'(hci_pkg::LR_RECIP);
        return FW'(p >> hci_pkg::LR_SHIFT);
    endfunction

    cls_t ca_reg, cb_reg;
    logic [8:0] t0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg <= classify(q_item.color_a);
            cb_reg <= classify(q_item.color_b);
            t0_reg <= q_item.t;
        end
    end

    // Stage 1..DL: four dividers (s and h for each colour)
    logic [NW-1:0]  sna, snb, hna, hnb;
    logic [DW-1:0]  sda, sdb, hda, hdb;
    logic [FW-1:0]  qsa, qsb, qha, qhb;

    assign sna = NW'({ca_reg.diff, FB'(0)});
    assign snb = NW'({cb_reg.diff, FB'(0)});
    assign sda = ca_reg.grey ? DW'(1) :
                 (ca_reg.sum < 9'd255 ? DW'(ca_reg.sum)
                                      : DW'(10'd510 - {1'b0, ca_reg.sum}));
    assign sdb = cb_reg.grey ? DW'(1) :
                 (cb_reg.sum < 9'd255 ? DW'(cb_reg.sum)
                                      : DW'(10'd510 - {1'b0, cb_reg.sum}));
    assign hna = {ca_reg.hnum, FB'(0)};
    assign hnb = {cb_reg.hnum, FB'(0)};
    assign hda = ca_reg.grey ? DW'(1) : DW'(ca_reg.diff) * DW'(6);
    assign hdb = cb_reg.grey ? DW'(1) : DW'(cb_reg.diff) * DW'(6);

    hci_div u_sa (.clk(clk), .en(en), .num(sna), .den(sda), .quo(qsa));
    hci_div u_sb (.clk(clk), .en(en), .num(snb), .den(sdb), .quo(qsb));
    hci_div u_ha (.clk(clk), .en(en), .num(hna), .den(hda), .quo(qha));
    hci_div u_hb (.clk(clk), .en(en), .num(hnb), .den(hdb), .quo(qhb));

    // Carry fraction, grey flags and lightness alongside the dividers
    typedef struct packed {
        logic [8:0]    t;
        logic          ga;
        logic          gb;
        logic [FW-1:0] la;
        logic [FW-1:0] lb;
    } tag_t;

    tag_t tag_in;
    tag_t tag_reg [DL];

    always_comb
    begin
        tag_in.t  = t0_reg;
        tag_in.ga = ca_reg.grey;
        tag_in.gb = cb_reg.grey;
        tag_in.la = lightness(ca_reg.sum);
        tag_in.lb = lightness(cb_reg.sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DL; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    logic [8:0]    td;
    logic          ga, gb;
    logic [FW-1:0] la0, lb0;
    assign td  = tag_reg[DL-1].t;
    assign ga  = tag_reg[DL-1].ga;
    assign gb  = tag_reg[DL-1].gb;
    assign la0 = tag_reg[DL-1].la;
    assign lb0 = tag_reg[DL-1].lb;

    // Blend stage
    localparam int BW = FW + 9;
    hci_pkg::hsl_t m_reg;

    always_ff @(posedge clk)
    begin
        logic [FW-1:0] sa, sb, ha, hb;
        logic signed [FW+2:0] h1, h2, dh;
        logic [BW-1:0] bs, bl;
        logic signed [FW+12:0] acc;
        logic signed [FW+4:0] hh;
        if (en)
        begin
            sa = ga ? '0 : qsa;
            sb = gb ? '0 : qsb;
            ha = ga ? '0 : qha;
            hb = gb ? '0 : qhb;
            bs = (BW'(sa) * BW'(9'd256 - td) + BW'(sb) * BW'(td)) >> 8;
            bl = (BW'(la0) * BW'(9'd256 - td) + BW'(lb0) * BW'(td)) >> 8;
            h1 = $signed({3'b000, ha});
            h2 = $signed({3'b000, hb});
            dh = h2 - h1;
            if (2 * dh > $signed({3'b000, hci_pkg::ONE_FX}) ||
                -2 * dh > $signed({3'b000, hci_pkg::ONE_FX}))
                h2 = (h1 > h2) ? h2 + $signed({3'b000, hci_pkg::ONE_FX})
                               : h2 - $signed({3'b000, hci_pkg::ONE_FX});
            acc = (FW+13)'(h1) * $signed({5'b0, 9'd256 - td})
                + (FW+13)'(h2) * $signed({5'b0, td})
                + $signed((FW+13)'({hci_pkg::ONE_FX, 8'd0}));
            hh = $signed((FW+5)'(acc >>> 8)) - $signed((FW+5)'(hci_pkg::ONE_FX));
            if (hh < 0)
                hh = hh + $signed((FW+5)'(hci_pkg::ONE_FX));
            if (hh > $signed((FW+5)'(hci_pkg::ONE_FX)))
                hh = hh - $signed((FW+5)'(hci_pkg::ONE_FX));
            m_reg.s <= FW'(bs);
            m_reg.l <= FW'(bl);
            m_reg.h <= FW'(hh);
        end
    end

    // RGB stage A: v1, v2
    logic [FW:0]   v1_reg, v2_reg;
    hci_pkg::hsl_t ma_reg;
    always_ff @(posedge clk)
    begin
        logic [2*FW+1:0] p;
        logic [FW+1:0] v2;
        if (en)
        begin
            if (2 * (FW+1)'(m_reg.l) < (FW+1)'(hci_pkg::ONE_FX))
            begin
                p  = (2*FW+2)'(m_reg.l) *
                     ((2*FW+2)'(hci_pkg::ONE_FX) + (2*FW+2)'(m_reg.s));
                v2 = (FW+2)'(p >> FB);
            end
            else
            begin
                p  = (2*FW+2)'(m_reg.s) * (2*FW+2)'(m_reg.l);
                v2 = (FW+2)'(m_reg.l) + (FW+2)'(m_reg.s) - (FW+2)'(p >> FB);
            end
            v2_reg <= (FW+1)'(v2);
            v1_reg <= (FW+1)'((FW+2)'({m_reg.l, 1'b0}) - v2);
            ma_reg <= m_reg;
        end
    end

    // RGB stage B: hue selection and scale factor per channel
    function automatic logic [FW-1:0] wrap_h(input logic signed [FW+2:0] vh);
        logic signed [FW+2:0] x;
        x = vh;
        if (x < 0) x = x + $signed((FW+3)'(hci_pkg::ONE_FX));
        if (x > $signed((FW+3)'(hci_pkg::ONE_FX))) x = x - $signed((FW+3)'(hci_pkg::ONE_FX));
        return FW'(x);
    endfunction

    typedef enum logic [1:0] {
        SEL_RAMP,
        SEL_V2,
        SEL_FALL,
        SEL_V1
    } hue_sel_t;

    typedef struct packed {
        hue_sel_t       sel;
        logic [FW+3:0]  k;
    } hc_t;

    function automatic hc_t hsel(input logic [FW-1:0] h);
        hc_t o;
        logic [FW+3:0] h6;
        h6 = (FW+4)'(h) * (FW+4)'(6);
        o.k = '0;
        if (h6 < (FW+4)'(hci_pkg::ONE_FX))
        begin
            o.sel = SEL_RAMP; o.k = h6;
        end
        else if (2 * (FW+2)'(h) < (FW+2)'(hci_pkg::ONE_FX))
            o.sel = SEL_V2;
        else if (3 * (FW+3)'(h) < 2 * (FW+3)'(hci_pkg::ONE_FX))
        begin
            o.sel = SEL_FALL;
            o.k = (FW+4)'(hci_pkg::TWO_THIRDS_FX - h) * (FW+4)'(6);
        end
        else
            o.sel = SEL_V1;
        return o;
    endfunction

    hc_t cr_reg, cg_reg, cbl_reg;
    logic [FW:0] v1b_reg, v2b_reg;
    logic        s0_reg;
    logic [FW-1:0] lb_reg;
    always_ff @(posedge clk)
    begin
        logic signed [FW+2:0] hs;
        if (en)
        begin
            hs = $signed((FW+3)'(ma_reg.h));
            cr_reg  <= hsel(wrap_h(hs + $signed((FW+3)'(hci_pkg::THIRD_FX))));
            cg_reg  <= hsel(wrap_h(hs));
            cbl_reg <= hsel(wrap_h(hs - $signed((FW+3)'(hci_pkg::THIRD_FX))));
            v1b_reg <= v1_reg;
            v2b_reg <= v2_reg;
            s0_reg  <= (ma_reg.s == '0);
            lb_reg  <= ma_reg.l;
        end
    end

    // RGB stage C: finish channels and convert to bytes
    function automatic logic [7:0] to_byte(input logic [FW:0] v);
        logic [FW+8:0] c;
        c = ((FW+9)'(v) * (FW+9)'(255)) >> FB;
        return (c > (FW+9)'(255)) ? 8'd255 : 8'(c);
    endfunction

    function automatic logic [FW:0] chan(input hc_t c, input logic [FW:0] v1,
                                         input logic [FW:0] v2);
        logic [2*FW+5:0] p;
        logic [FW:0] r;
        p = (2*FW+6)'(v2 - v1) * (2*FW+6)'(c.k);
        unique case (c.sel)
            SEL_RAMP, SEL_FALL: r = v1 + (FW+1)'(p >> FB);
            SEL_V2:             r = v2;
            default:            r = v1;
        endcase
        return r;
    endfunction

    logic [23:0] rgb_reg;
    always_ff @(posedge clk)
    begin
        logic [7:0] c;
        if (en)
        begin
            c = to_byte((FW+1)'(lb_reg));
            if (s0_reg)
                rgb_reg <= {c, c, c};
            else
                rgb_reg <= {to_byte(chan(cr_reg, v1b_reg, v2b_reg)),
                            to_byte(chan(cg_reg, v1b_reg, v2b_reg)),
                            to_byte(chan(cbl_reg, v1b_reg, v2b_reg))};
        end
    end

    // Output register: load when the last stage holds a beat and the slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_reg[NS-1] ? 1'b1 : (out_valid_reg && !ready);
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[NS-1])
            out_reg <= rgb_reg;
    end

    assign valid     = out_valid_reg;
    assign color_out = out_reg;
endmodule

/* design/hsl_colour_interpolator.sv */
// HSL colour interpolator: accepts one beat per cycle while in_ready is high, one result per beat.
// From input accept to out_valid a beat passes classify (straight from the queue), the dividers,
// blend, three RGB stages and the output register.
// Throughput is one beat per cycle; the whole back pipeline stalls only when the output is held.
// Reset is asynchronous active low and clears queue and valid bits only.
// Depends on hci_pkg, hci_front, hci_back.
module hsl_colour_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] color_a,
    input  logic [23:0] color_b,
    input  logic [8:0]  mix_fraction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] color_out
);
    logic           q_valid, q_pop;
    hci_pkg::item_t q_item;

    hci_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .color_a(color_a), .color_b(color_b), .mix_fraction(mix_fraction),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    hci_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .valid(out_valid), .ready(out_ready), .color_out(color_out)
    );
endmodule
